// File: rtl/rbt_pkg.sv
// Shared types and constants of the resource barrier tracker.
// No dependencies; every other file but rbt_ram imports this package.
`default_nettype none
package rbt_pkg;

    localparam int ID_W    = 8;
    localparam int STATE_W = 4;
    localparam int LIST_W  = 4;
    localparam int CMD_W   = 12;
    localparam int KIND_W  = 2;

    // Request modes carried in s_tuser
    typedef enum logic [1:0] {
        MODE_REGISTER   = 2'd0,
        MODE_TRANSITION = 2'd1,
        MODE_COMMIT     = 2'd2,
        MODE_CLEAR      = 2'd3
    } mode_t;

    localparam logic [KIND_W-1:0] KIND_IMMEDIATE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BEGIN     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END       = 2'd2;

    // Controller states, one-hot
    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_EVAL   = 6'b000100,
        ST_COMMIT = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_CLEAR  = 6'b100000
    } ctrl_state_t;

    typedef struct packed {
        mode_t              mode;
        logic [ID_W-1:0]    resource_id;
        logic [STATE_W-1:0] target_state;
        logic [LIST_W-1:0]  list_number;
        logic [CMD_W-1:0]   command_number;
    } item_t;

    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] state;
    } reg_entry_t;

    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] state;
        logic [LIST_W-1:0]  list;
        logic [CMD_W-1:0]   command;
    } trk_entry_t;

    typedef struct packed {
        logic [KIND_W-1:0]  barrier_kind;
        logic [LIST_W-1:0]  attach_list;
        logic [CMD_W-1:0]   attach_command;
        logic               attach_after;
        logic [ID_W-1:0]    barrier_resource;
        logic [STATE_W-1:0] before_state;
        logic [STATE_W-1:0] after_state;
        logic               uav_barrier;
        logic               status;
        logic               last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
        logic       trk_we;
        trk_entry_t trk_wdata;
    } eval_out_t;

endpackage
`default_nettype wire

// File: rtl/rbt_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for both state tables; no package dependency.
`default_nettype none
module rbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/rbt_eval.sv
// Transition decision: from the two table entries of a resource, works out
// the barrier words and the tracking write-back. Depends on rbt_pkg.
`default_nettype none
module rbt_eval (
    input  rbt_pkg::item_t                   item,
    input  wire logic                        id_ok,
    input  wire logic                        cmd_ok,
    input  rbt_pkg::reg_entry_t              reg_rd,
    input  rbt_pkg::trk_entry_t              trk_rd,
    input  wire logic [rbt_pkg::STATE_W-1:0] uav_code,
    output rbt_pkg::eval_out_t               ev
);
    import rbt_pkg::*;

    logic               tracked;
    logic               known;
    logic [STATE_W-1:0] prev;
    logic               change;
    logic               uav_hit;
    logic               split;
    logic [CMD_W:0]     cmd_gap;
    result_t            base;

    always_comb
    begin
        tracked = id_ok && trk_rd.valid;
        known   = tracked || (id_ok && reg_rd.valid);
        prev    = tracked ? trk_rd.state : reg_rd.state;
        change  = prev != item.target_state;
        uav_hit = !change && (prev == uav_code);
        // signed distance to last use; split when >= 2 or another list
        cmd_gap = {1'b0, item.command_number} - {1'b0, trk_rd.command};
        split   = tracked && ((trk_rd.list != item.list_number)
                  || (!cmd_gap[CMD_W] && (cmd_gap[CMD_W-1:1] != '0)));

        base.barrier_kind     = KIND_IMMEDIATE;
        base.attach_list      = item.list_number;
        base.attach_command   = item.command_number;
        base.attach_after     = 1'b0;
        base.barrier_resource = item.resource_id;
        base.before_state     = change ? prev : '0;
        base.after_state      = change ? item.target_state : '0;
        base.uav_barrier      = !change;
        base.status           = 1'b0;
        base.last_of_run      = 1'b1;

        ev.count             = 2'd0;
        ev.res0              = base;
        ev.res1              = base;
        ev.trk_we            = 1'b0;
        ev.trk_wdata.valid   = 1'b1;
        ev.trk_wdata.state   = item.target_state;
        ev.trk_wdata.list    = item.list_number;
        ev.trk_wdata.command = item.command_number;

        if (cmd_ok)
        begin
            if (!known)
            begin
                ev.count             = 2'd1;
                ev.res0.before_state = '0;
                ev.res0.after_state  = '0;
                ev.res0.uav_barrier  = 1'b0;
                ev.res0.status       = 1'b1;
            end
            else
            begin
                // stored state always ends up as the requested one
                ev.trk_we = 1'b1;
                if (change || uav_hit)
                begin
                    if (split)
                    begin
                        ev.count               = 2'd2;
                        ev.res0.barrier_kind   = KIND_BEGIN;
                        ev.res0.attach_list    = trk_rd.list;
                        ev.res0.attach_command = trk_rd.command;
                        ev.res0.attach_after   = 1'b1;
                        ev.res0.last_of_run    = 1'b0;
                        ev.res1.barrier_kind   = KIND_END;
                    end
                    else
                    begin
                        ev.count = 2'd1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/rbt_out_buf.sv
// Two-word output queue holding the barrier words of one request.
// Depends on rbt_pkg.
`default_nettype none
module rbt_out_buf (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire logic [1:0] load_count,
    input  rbt_pkg::result_t load_res0,
    input  rbt_pkg::result_t load_res1,
    output logic            empty,
    output logic            out_valid,
    input  wire logic       out_ready,
    output rbt_pkg::result_t out_res
);
    import rbt_pkg::*;

    result_t    slot0_reg;
    result_t    slot1_reg;
    logic [1:0] cnt_reg;

    assign empty     = cnt_reg == 2'd0;
    assign out_valid = !empty;
    assign out_res   = slot0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (load && empty)
        begin
            cnt_reg <= load_count;
        end
        else if (!empty && out_ready)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && empty)
        begin
            slot0_reg <= load_res0;
            slot1_reg <= load_res1;
        end
        else if (!empty && out_ready)
        begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule
`default_nettype wire

// File: rtl/resource_barrier_tracker.sv
// Resource barrier tracker, top level: controller, table RAMs, output queue.
// Depends on rbt_pkg, rbt_ram, rbt_eval, rbt_out_buf.
//
// Usage
//   s_* : request words. s_tuser = mode (register / transition / commit /
//         clear). s_tdata = resource, target state, list, command.
//   m_* : barrier words. tuser = kind, UAV flag, error status; tlast marks
//         the final word of one request.
//   cfg_wen/cfg_wdata : UAV state code, write while idle only.
// Timing
//   Register and transition requests read the registered and tracked
//   entries from their RAMs as they are accepted, then evaluate and write
//   back in the evaluate state. Up to two barrier words follow, the first
//   in the cycle after the evaluate state loads the output queue.
//   Commit sweeps both tables, then passes a drain state; clear sweeps
//   the tracking table. s_tready is low meanwhile.
// Reset
//   After rst_n releases, a clearing pass over every entry zeroes both
//   tables; s_tready stays low until it ends.
// Stall
//   A new request is taken while barrier words still wait; a transition
//   then holds in its evaluate cycle until the output queue has drained.
`default_nettype none
module resource_barrier_tracker #(
    parameter int RESOURCE_COUNT = 256,
    parameter int LIST_COUNT     = 16,
    parameter int COMMAND_COUNT  = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // fields from bit 0: resource_id[7:0], target_state[11:8],
    // list_number[15:12], command_number[27:16], zero fill [31:28]
    input  wire logic [31:0] s_tdata,
    // mode[1:0]
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // fields from bit 0: attach_list[3:0], attach_command[15:4],
    // attach_after[16], barrier_resource[24:17], before_state[28:25],
    // after_state[32:29], zero fill [39:33]
    output logic [39:0]      m_tdata,
    // barrier_kind[1:0], uav_barrier[2], status[3]
    output logic [3:0]       m_tuser,
    output logic             m_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_wen,
    input  wire logic [3:0]  cfg_wdata
);
    import rbt_pkg::*;

    localparam int RES_AW = (RESOURCE_COUNT > 1) ? $clog2(RESOURCE_COUNT) : 1;
    localparam logic [RES_AW-1:0] SWEEP_LAST = RES_AW'(RESOURCE_COUNT - 1);

    ctrl_state_t        state_reg, state_next;
    logic [RES_AW-1:0]  sweep_reg, sweep_next;
    logic               cmt_pend_reg;
    logic [RES_AW-1:0]  cmt_addr_reg;
    logic [STATE_W-1:0] uav_code_reg;
    item_t              item_reg;

    item_t              s_item;
    logic               accept;
    logic               sweep_done;

    logic [16:0]        in_id_ext;
    logic [16:0]        item_id_ext;
    logic [RES_AW-1:0]  in_idx;
    logic [RES_AW-1:0]  item_idx;
    logic               id_ok;
    logic               cmd_ok;

    logic               rd_en;
    logic [RES_AW-1:0]  rd_addr;
    logic               reg_we;
    logic [RES_AW-1:0]  reg_waddr;
    reg_entry_t         reg_wdata;
    reg_entry_t         reg_rd;
    logic               trk_we;
    logic [RES_AW-1:0]  trk_waddr;
    trk_entry_t         trk_wdata;
    trk_entry_t         trk_rd;

    eval_out_t          ev;
    logic               ob_load;
    logic               ob_empty;
    result_t            ob_res;

    // request word unpacking
    assign s_item.mode           = mode_t'(s_tuser);
    assign s_item.resource_id    = s_tdata[7:0];
    assign s_item.target_state   = s_tdata[11:8];
    assign s_item.list_number    = s_tdata[15:12];
    assign s_item.command_number = s_tdata[27:16];

    assign s_tready = state_reg == ST_IDLE;
    assign accept   = s_tvalid && s_tready;

    // resource handles wider than the table fall outside it
    assign in_id_ext   = {9'd0, s_item.resource_id};
    assign item_id_ext = {9'd0, item_reg.resource_id};
    assign in_idx      = in_id_ext[RES_AW-1:0];
    assign item_idx    = item_id_ext[RES_AW-1:0];
    assign id_ok       = item_id_ext < 17'(RESOURCE_COUNT);
    assign cmd_ok      = ({5'd0, item_reg.list_number} < 9'(LIST_COUNT))
                      && ({5'd0, item_reg.command_number} < 17'(COMMAND_COUNT));

    assign sweep_done = sweep_reg == SWEEP_LAST;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uav_code_reg <= '0;
        end
        else if (cfg_wen)
        begin
            uav_code_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= s_item;
        end
    end

    // controller
    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        ob_load    = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                sweep_next = sweep_reg + RES_AW'(1);
                if (sweep_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                sweep_next = '0;
                if (accept)
                begin
                    unique case (s_item.mode)
                        MODE_COMMIT:                    state_next = ST_COMMIT;
                        MODE_CLEAR:                     state_next = ST_CLEAR;
                        MODE_REGISTER, MODE_TRANSITION: state_next = ST_EVAL;
                    endcase
                end
            end
            ST_EVAL:
            begin
                if (item_reg.mode != MODE_TRANSITION)
                begin
                    state_next = ST_IDLE;
                end
                else if (ob_empty)
                begin
                    ob_load    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_COMMIT:
            begin
                sweep_next = sweep_reg + RES_AW'(1);
                if (sweep_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                sweep_next = sweep_reg + RES_AW'(1);
                if (sweep_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            sweep_reg    <= '0;
            cmt_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            cmt_pend_reg <= state_reg == ST_COMMIT;
        end
    end

    always_ff @(posedge clk)
    begin
        cmt_addr_reg <= sweep_reg;
    end

    // RAM read side: request lookup, or commit walk
    assign rd_en   = accept || (state_reg == ST_COMMIT);
    assign rd_addr = (state_reg == ST_COMMIT) ? sweep_reg : in_idx;

    // registered table write port
    always_comb
    begin
        reg_we    = 1'b0;
        reg_waddr = item_idx;
        reg_wdata = '0;
        if (state_reg == ST_INIT)
        begin
            reg_we    = 1'b1;
            reg_waddr = sweep_reg;
        end
        else if (cmt_pend_reg)
        begin
            // entry read in the cycle before; copy only where both are valid
            reg_we          = reg_rd.valid && trk_rd.valid;
            reg_waddr       = cmt_addr_reg;
            reg_wdata.valid = 1'b1;
            reg_wdata.state = trk_rd.state;
        end
        else if (state_reg == ST_EVAL && item_reg.mode == MODE_REGISTER)
        begin
            reg_we          = id_ok;
            reg_wdata.valid = 1'b1;
            reg_wdata.state = item_reg.target_state;
        end
    end

    // tracking table write port
    always_comb
    begin
        trk_we    = 1'b0;
        trk_waddr = item_idx;
        trk_wdata = ev.trk_wdata;
        if (state_reg == ST_INIT || state_reg == ST_CLEAR)
        begin
            trk_we    = 1'b1;
            trk_waddr = sweep_reg;
            trk_wdata = '0;
        end
        else if (ob_load)
        begin
            trk_we = ev.trk_we;
        end
    end

    rbt_ram #(
        .WIDTH ($bits(reg_entry_t)),
        .DEPTH (RESOURCE_COUNT)
    ) u_reg_ram (
        .clk   (clk),
        .we    (reg_we),
        .waddr (reg_waddr),
        .wdata (reg_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (reg_rd)
    );

    rbt_ram #(
        .WIDTH ($bits(trk_entry_t)),
        .DEPTH (RESOURCE_COUNT)
    ) u_trk_ram (
        .clk   (clk),
        .we    (trk_we),
        .waddr (trk_waddr),
        .wdata (trk_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (trk_rd)
    );

    rbt_eval u_eval (
        .item     (item_reg),
        .id_ok    (id_ok),
        .cmd_ok   (cmd_ok),
        .reg_rd   (reg_rd),
        .trk_rd   (trk_rd),
        .uav_code (uav_code_reg),
        .ev       (ev)
    );

    rbt_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (ob_load),
        .load_count (ev.count),
        .load_res0  (ev.res0),
        .load_res1  (ev.res1),
        .empty      (ob_empty),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (ob_res)
    );

    // barrier word packing
    assign m_tdata = {7'd0, ob_res.after_state, ob_res.before_state,
                      ob_res.barrier_resource, ob_res.attach_after,
                      ob_res.attach_command, ob_res.attach_list};
    assign m_tuser = {ob_res.status, ob_res.uav_barrier, ob_res.barrier_kind};
    assign m_tlast = ob_res.last_of_run;

endmodule
`default_nettype wire

// File: rtl/rbt_checker.sv
// Port-level checks of the resource barrier tracker, bound to the top level.
// Depends on rbt_pkg and resource_barrier_tracker.
`default_nettype none
module rbt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [3:0]  m_tuser,
    input wire logic        m_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);
    import rbt_pkg::*;

    // one request at a time: ready drops after every accepted word
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted on consecutive cycles");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                 && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled barrier word changed");

    // split begin is always followed by its end; others close the run
    a_last_marking: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser[1:0] != KIND_BEGIN)))
        else $error("tlast does not match barrier kind");

    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[3] |-> (m_tuser[1:0] == KIND_IMMEDIATE)
                                   && !m_tuser[2] && m_tlast)
        else $error("malformed error word");

endmodule

bind resource_barrier_tracker rbt_checker u_rbt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
`default_nettype wire
